>>> rtl/ihrb_pkg.sv
// Shared constants, types and codes for the HEX record builder.
package ihrb_pkg;

  localparam int MAX_RECORD_BYTES = 32;
  localparam int ADDR_W = $clog2(MAX_RECORD_BYTES);
  localparam int FILL_W = $clog2(MAX_RECORD_BYTES + 1);
  localparam int LEN_W = 6;
  localparam int WADDR_W = 31;
  localparam int BADDR_W = 32;
  localparam int DATA_W = 32;
  localparam int PADDR_W = 3;

  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_RECORD_BYTES & ~1);
  localparam logic [LEN_W-1:0] LEN_RESET = 6'd16;

  localparam logic REG_LEN = 1'b0;
  localparam logic REG_ENDIAN = 1'b1;

  localparam logic [7:0] TYPE_DATA = 8'h00;
  localparam logic [7:0] TYPE_EOF = 8'h01;
  localparam logic [7:0] TYPE_EXT = 8'h04;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OPEN,
    ST_WR0,
    ST_WR1,
    ST_HDR_COUNT,
    ST_HDR_ADHI,
    ST_HDR_ADLO,
    ST_HDR_TYPE,
    ST_DATA,
    ST_CSUM,
    ST_ERR
  } state_t;

  typedef enum logic [1:0] {
    REC_DATA,
    REC_EXT,
    REC_EOF
  } rec_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       run_last;
    logic       err;
  } emit_t;

endpackage

>>> rtl/ihrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ihrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/intel_hex_record_builder_core.sv
// Intel HEX record builder: packs addressed words into binary HEX records.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+----------------------------------------
//   input    | in        | in_valid / in_stall  | word_address, word_data, last_word
//   output   | out       | out_valid / out_stall| record_byte, record_first, record_last,
//            |           |                      | run_last, config_error
//   config   | in        | APB psel / penable   | record_data_bytes @0, little_endian @4
//
// A word that extends the open record is accepted, then written into the record RAM in
// two writes, as the RAM has one write port. A closing record is sent one byte per cycle
// unless the output stalls (5 + data count), then a new record opens; a type-04 record is
// 7 bytes; the last word adds its flush and a 5-byte end record. Reset clears control
// state only; the record RAM is not cleared. A stall on the output holds the output
// register and the record sequencer; the input is stalled whenever the sequencer is busy.
module intel_hex_record_builder_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ihrb_pkg::WADDR_W-1:0]   word_address,
  input  logic [15:0]                    word_data,
  input  logic                           last_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     record_byte,
  output logic                           record_first,
  output logic                           record_last,
  output logic                           run_last,
  output logic                           config_error,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ihrb_pkg::PADDR_W-1:0]   paddr,
  input  logic [ihrb_pkg::DATA_W-1:0]    pwdata,
  output logic [ihrb_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  ihrb_pkg::state_t                  state;
  ihrb_pkg::state_t                  state_next;
  ihrb_pkg::rec_kind_t               kind;
  logic                              closing;
  logic                              started;
  logic [ihrb_pkg::FILL_W-1:0]       fill;
  logic [ihrb_pkg::BADDR_W-1:0]      base;
  logic [ihrb_pkg::WADDR_W-1:0]      prev_addr;
  logic [ihrb_pkg::LEN_W-1:0]        record_data_bytes;
  logic                              little_endian;
  logic [ihrb_pkg::ADDR_W-1:0]       rd_ptr;
  logic [ihrb_pkg::ADDR_W-1:0]       rd_ptr_next;

  logic [ihrb_pkg::WADDR_W-1:0]      in_addr;
  logic [15:0]                       in_data;
  logic                              in_last;
  logic [7:0]                        sum;
  ihrb_pkg::emit_t                   out_q;
  logic                              out_valid_q;
  ihrb_pkg::emit_t                   emit;
  logic                              emit_valid;

  logic                              accept;
  logic                              out_free;
  logic                              load;
  logic                              cfg_we;
  logic                              cfg_bad;
  logic [ihrb_pkg::LEN_W-1:0]        limit;
  logic                              step_ok;
  logic [15:0]                       top_low;
  logic                              close;
  logic                              ext_needed;
  logic [15:0]                       upper;
  logic [ihrb_pkg::FILL_W-1:0]       last_idx;
  logic                              at_last_idx;

  logic                              ram_we;
  logic [ihrb_pkg::ADDR_W-1:0]       ram_waddr;
  logic [7:0]                        ram_wdata;
  logic [7:0]                        ram_rdata;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == ihrb_pkg::REG_ENDIAN) ? ihrb_pkg::DATA_W'(little_endian)
                                                     : ihrb_pkg::DATA_W'(record_data_bytes);

  assign in_stall = (state != ihrb_pkg::ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign load = emit_valid && out_free;

  assign cfg_bad = (record_data_bytes == '0) || record_data_bytes[0];
  assign limit = (record_data_bytes > ihrb_pkg::LEN_CAP) ? ihrb_pkg::LEN_CAP
                                                         : record_data_bytes;
  assign step_ok = ({1'b0, word_address} == ({1'b0, prev_addr} + ihrb_pkg::BADDR_W'(1)));
  assign top_low = base[15:0] + 16'(fill);
  assign close = (top_low == 16'd0) || !step_ok
                 || (ihrb_pkg::LEN_W'(fill) >= limit);
  assign upper = in_addr[ihrb_pkg::WADDR_W-1:ihrb_pkg::WADDR_W-16];
  assign ext_needed = (upper != base[31:16]);
  assign last_idx = (kind == ihrb_pkg::REC_EXT) ? ihrb_pkg::FILL_W'(1)
                                                : fill - ihrb_pkg::FILL_W'(1);
  assign at_last_idx = (ihrb_pkg::FILL_W'(rd_ptr) == last_idx);

  assign out_valid = out_valid_q;
  assign record_byte = out_q.data;
  assign record_first = out_q.first;
  assign record_last = out_q.last;
  assign run_last = out_q.run_last;
  assign config_error = out_q.err;

  ihrb_ram #(
    .WIDTH(8),
    .DEPTH(ihrb_pkg::MAX_RECORD_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_ptr_next),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ihrb_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (cfg_bad) begin
            state_next = last_word ? ihrb_pkg::ST_ERR : ihrb_pkg::ST_IDLE;
          end else if (!started) begin
            state_next = ihrb_pkg::ST_OPEN;
          end else if (close) begin
            state_next = (fill != '0) ? ihrb_pkg::ST_HDR_COUNT : ihrb_pkg::ST_OPEN;
          end else begin
            state_next = ihrb_pkg::ST_WR0;
          end
        end
      end
      ihrb_pkg::ST_OPEN: begin
        state_next = ext_needed ? ihrb_pkg::ST_HDR_COUNT : ihrb_pkg::ST_WR0;
      end
      ihrb_pkg::ST_WR0: begin
        state_next = ihrb_pkg::ST_WR1;
      end
      ihrb_pkg::ST_WR1: begin
        state_next = in_last ? ihrb_pkg::ST_HDR_COUNT : ihrb_pkg::ST_IDLE;
      end
      ihrb_pkg::ST_HDR_COUNT: begin
        if (out_free) state_next = ihrb_pkg::ST_HDR_ADHI;
      end
      ihrb_pkg::ST_HDR_ADHI: begin
        if (out_free) state_next = ihrb_pkg::ST_HDR_ADLO;
      end
      ihrb_pkg::ST_HDR_ADLO: begin
        if (out_free) state_next = ihrb_pkg::ST_HDR_TYPE;
      end
      ihrb_pkg::ST_HDR_TYPE: begin
        if (out_free) begin
          state_next = (kind == ihrb_pkg::REC_EOF) ? ihrb_pkg::ST_CSUM : ihrb_pkg::ST_DATA;
        end
      end
      ihrb_pkg::ST_DATA: begin
        if (out_free && at_last_idx) state_next = ihrb_pkg::ST_CSUM;
      end
      ihrb_pkg::ST_CSUM: begin
        if (out_free) begin
          unique case (kind)
            ihrb_pkg::REC_EXT:  state_next = ihrb_pkg::ST_WR0;
            ihrb_pkg::REC_DATA: state_next = closing ? ihrb_pkg::ST_HDR_COUNT
                                                     : ihrb_pkg::ST_OPEN;
            ihrb_pkg::REC_EOF:  state_next = ihrb_pkg::ST_IDLE;
            default:            state_next = ihrb_pkg::ST_IDLE;
          endcase
        end
      end
      ihrb_pkg::ST_ERR: begin
        if (out_free) state_next = ihrb_pkg::ST_IDLE;
      end
      default: state_next = ihrb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    emit = '0;
    emit_valid = 1'b0;
    ram_we = 1'b0;
    ram_waddr = fill[ihrb_pkg::ADDR_W-1:0];
    ram_wdata = little_endian ? in_data[7:0] : in_data[15:8];
    rd_ptr_next = '0;
    unique case (state)
      ihrb_pkg::ST_WR0: begin
        ram_we = 1'b1;
      end
      ihrb_pkg::ST_WR1: begin
        ram_we = 1'b1;
        ram_waddr = fill[ihrb_pkg::ADDR_W-1:0] + ihrb_pkg::ADDR_W'(1);
        ram_wdata = little_endian ? in_data[15:8] : in_data[7:0];
      end
      ihrb_pkg::ST_HDR_COUNT: begin
        emit_valid = 1'b1;
        emit.first = 1'b1;
        unique case (kind)
          ihrb_pkg::REC_DATA: emit.data = 8'(fill);
          ihrb_pkg::REC_EXT:  emit.data = 8'd2;
          ihrb_pkg::REC_EOF:  emit.data = 8'd0;
          default:            emit.data = 8'd0;
        endcase
      end
      ihrb_pkg::ST_HDR_ADHI: begin
        emit_valid = 1'b1;
        emit.data = (kind == ihrb_pkg::REC_DATA) ? base[15:8] : 8'd0;
      end
      ihrb_pkg::ST_HDR_ADLO: begin
        emit_valid = 1'b1;
        emit.data = (kind == ihrb_pkg::REC_DATA) ? base[7:0] : 8'd0;
      end
      ihrb_pkg::ST_HDR_TYPE: begin
        emit_valid = 1'b1;
        unique case (kind)
          ihrb_pkg::REC_DATA: emit.data = ihrb_pkg::TYPE_DATA;
          ihrb_pkg::REC_EXT:  emit.data = ihrb_pkg::TYPE_EXT;
          ihrb_pkg::REC_EOF:  emit.data = ihrb_pkg::TYPE_EOF;
          default:            emit.data = ihrb_pkg::TYPE_DATA;
        endcase
      end
      ihrb_pkg::ST_DATA: begin
        emit_valid = 1'b1;
        if (kind == ihrb_pkg::REC_EXT) begin
          emit.data = rd_ptr[0] ? upper[7:0] : upper[15:8];
        end else begin
          emit.data = ram_rdata;
        end
        rd_ptr_next = out_free ? rd_ptr + ihrb_pkg::ADDR_W'(1) : rd_ptr;
      end
      ihrb_pkg::ST_CSUM: begin
        emit_valid = 1'b1;
        emit.data = 8'd0 - sum;
        emit.last = 1'b1;
        unique case (kind)
          ihrb_pkg::REC_DATA: emit.run_last = !closing && !in_last && !ext_needed;
          ihrb_pkg::REC_EXT:  emit.run_last = !in_last;
          ihrb_pkg::REC_EOF:  emit.run_last = 1'b1;
          default:            emit.run_last = 1'b0;
        endcase
      end
      ihrb_pkg::ST_ERR: begin
        emit_valid = 1'b1;
        emit.run_last = 1'b1;
        emit.err = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ihrb_pkg::ST_IDLE;
      kind <= ihrb_pkg::REC_DATA;
      closing <= 1'b0;
      started <= 1'b0;
      fill <= '0;
      base <= '0;
      prev_addr <= '0;
      record_data_bytes <= ihrb_pkg::LEN_RESET;
      little_endian <= 1'b1;
      rd_ptr <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state <= state_next;
      rd_ptr <= rd_ptr_next;
      if (cfg_we) begin
        if (paddr[2] == ihrb_pkg::REG_ENDIAN) begin
          little_endian <= pwdata[0];
        end else begin
          record_data_bytes <= pwdata[ihrb_pkg::LEN_W-1:0];
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall) begin
        out_valid_q <= 1'b0;
      end
      unique case (state)
        ihrb_pkg::ST_IDLE: begin
          if (accept && !cfg_bad && started && close && (fill != '0)) begin
            kind <= ihrb_pkg::REC_DATA;
            closing <= 1'b0;
          end
        end
        ihrb_pkg::ST_OPEN: begin
          base <= {in_addr, 1'b0};
          fill <= '0;
          started <= 1'b1;
          if (ext_needed) begin
            kind <= ihrb_pkg::REC_EXT;
            closing <= 1'b0;
          end
        end
        ihrb_pkg::ST_WR1: begin
          fill <= fill + ihrb_pkg::FILL_W'(2);
          prev_addr <= in_addr;
          if (in_last) begin
            kind <= ihrb_pkg::REC_DATA;
            closing <= 1'b1;
          end
        end
        ihrb_pkg::ST_CSUM: begin
          if (out_free) begin
            if (kind == ihrb_pkg::REC_DATA && closing) begin
              kind <= ihrb_pkg::REC_EOF;
            end else if (kind == ihrb_pkg::REC_EOF) begin
              started <= 1'b0;
              fill <= '0;
              base <= '0;
              prev_addr <= '0;
            end
          end
        end
        ihrb_pkg::ST_ERR: begin
          if (out_free) begin
            started <= 1'b0;
            fill <= '0;
            base <= '0;
            prev_addr <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_addr <= word_address;
      in_data <= word_data;
      in_last <= last_word;
    end
    if (load) begin
      out_q <= emit;
      sum <= (state == ihrb_pkg::ST_HDR_COUNT) ? emit.data : sum + emit.data;
    end
  end

`ifndef SYNTH
  a_open_on_start: assert property (@(posedge clk) disable iff (rst)
    (accept && !cfg_bad && !started) |=> (state == ihrb_pkg::ST_OPEN))
    else $error("first word of a stream did not open a record");

  a_fill_even: assert property (@(posedge clk) disable iff (rst)
    (fill[0] == 1'b0) && (fill <= ihrb_pkg::FILL_W'(ihrb_pkg::MAX_RECORD_BYTES)))
    else $error("record fill count odd or out of range");

  a_error_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && config_error) |-> (run_last && !record_first && !record_last
                                     && (record_byte == 8'd0)))
    else $error("error item carries record content");

  a_restart_after_end: assert property (@(posedge clk) disable iff (rst)
    (state == ihrb_pkg::ST_CSUM && kind == ihrb_pkg::REC_EOF && out_free)
    |=> (!started && (fill == '0) && (state == ihrb_pkg::ST_IDLE)))
    else $error("stream not restarted after end record");
`endif

endmodule
